// File: sv/bbcm_pkg.sv
// Shared types and constants of the block buffer cache manager.
package bbcm_pkg;

  localparam int unsigned PTR_W  = 6;
  localparam int unsigned SLOT_W = 5;
  // end-of-list marker in the LRU free list links
  localparam logic [PTR_W-1:0] NIL_SLOT = 6'd63;

  typedef enum logic [2:0] {
    MODE_FETCH      = 3'd0,
    MODE_RELEASE    = 3'd1,
    MODE_IO_DONE    = 3'd2,
    MODE_INVAL_DEV  = 3'd3,
    MODE_FLUSH      = 3'd4,
    MODE_MARK_VALID = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    RS_HIT         = 3'd0,
    RS_ALLOC       = 3'd1,
    RS_WB          = 3'd2,
    RS_WAIT_LOCKED = 3'd3,
    RS_WAIT_FREE   = 3'd4,
    RS_DONE        = 3'd5,
    RS_IO_ERR      = 3'd6
  } res_st_e;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_REQ,
    SEL_CUR
  } slot_sel_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_CUR,
    OP_INC,
    OP_CUR_HEAD,
    OP_CUR_NEXT,
    OP_UNLINK_LOCK,
    OP_MARK_OLD,
    OP_RETAG,
    OP_SET_FLAGS,
    OP_PUSH_HEAD_A,
    OP_PUSH_HEAD_B,
    OP_PUSH_TAIL_A,
    OP_PUSH_TAIL_B,
    OP_MARK_VALID,
    OP_INVAL_NEXT
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_MISS_CHECK,
    S_MISS_UNLINK,
    S_MISS_EVAL,
    S_MISS_HEAD,
    S_PUSH_A,
    S_PUSH_B,
    S_WALK_CHECK,
    S_WALK_EVAL,
    S_FL_WB,
    S_FL_NEXT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e    op;
    logic      emit;
    res_st_e   st;
    slot_sel_e sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       slot_ok;
    logic       match;
    logic       locked_cur;
    logic       delayed_cur;
    logic       cur_nil;
    logic       cur_last;
    logic       to_head;
    logic       failed;
    logic       out_free;
  } dp_stat_t;

endpackage

// File: sv/block_buffer_cache_manager_core.sv
// Top level of the block buffer cache manager: controller plus datapath.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------------
//   in      | input     | in_valid_i/in_stall_o | mode, req_device, req_block, req_slot,
//           |           |                       | mark_delayed, io_failed
//   out     | output    | out_valid_o/out_stall_i | status, res_slot, res_device,
//           |           |                       | res_block, last
//
// One item at a time. A fetch scans the tag memory one slot after another, and a miss then
// pops the free list: each delayed slot popped is reported as a write-back before the slot
// that is retagged, and a wait-free result is given when the list runs out. Invalidate and
// flush walk the free list slot by slot. The single read port of the tag and link memories
// serialises these steps. Reset needs no clearing pass: unwritten link entries read as the
// initial chain. A stalled result holds the sequencer at its next result.
module block_buffer_cache_manager_core #(
  parameter int unsigned SLOTS       = 32,
  parameter int unsigned DEVICE_BITS = 8,
  parameter int unsigned BLOCK_BITS  = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  mode_i,
  input  logic [DEVICE_BITS-1:0]      req_device_i,
  input  logic [BLOCK_BITS-1:0]       req_block_i,
  input  logic [bbcm_pkg::SLOT_W-1:0] req_slot_i,
  input  logic                        mark_delayed_i,
  input  logic                        io_failed_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [bbcm_pkg::SLOT_W-1:0] res_slot_o,
  output logic [DEVICE_BITS-1:0]      res_device_o,
  output logic [BLOCK_BITS-1:0]       res_block_o,
  output logic                        last_o
);
  import bbcm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bbcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bbcm_dp #(
    .SLOTS       (SLOTS),
    .DEVICE_BITS (DEVICE_BITS),
    .BLOCK_BITS  (BLOCK_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_i),
    .req_device_i   (req_device_i),
    .req_block_i    (req_block_i),
    .req_slot_i     (req_slot_i),
    .mark_delayed_i (mark_delayed_i),
    .io_failed_i    (io_failed_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .res_slot_o     (res_slot_o),
    .res_device_o   (res_device_o),
    .res_block_o    (res_block_o),
    .last_o         (last_o)
  );

endmodule

// File: sv/bbcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bbcm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bbcm_dp.sv
// Datapath: tag and link memories, slot flags, list head/tail and result register.
module bbcm_dp #(
  parameter int unsigned SLOTS       = 32,
  parameter int unsigned DEVICE_BITS = 8,
  parameter int unsigned BLOCK_BITS  = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [2:0]                    mode_i,
  input  logic [DEVICE_BITS-1:0]        req_device_i,
  input  logic [BLOCK_BITS-1:0]         req_block_i,
  input  logic [bbcm_pkg::SLOT_W-1:0]   req_slot_i,
  input  logic                          mark_delayed_i,
  input  logic                          io_failed_i,
  input  bbcm_pkg::dp_cmd_t             cmd_i,
  output bbcm_pkg::dp_stat_t            stat_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [2:0]                    status_o,
  output logic [bbcm_pkg::SLOT_W-1:0]   res_slot_o,
  output logic [DEVICE_BITS-1:0]        res_device_o,
  output logic [BLOCK_BITS-1:0]         res_block_o,
  output logic                          last_o
);
  import bbcm_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned TW = DEVICE_BITS + BLOCK_BITS;

  // request registers
  logic [2:0]             mode_q;
  logic [DEVICE_BITS-1:0] dev_q;
  logic [BLOCK_BITS-1:0]  blk_q;
  logic [SLOT_W-1:0]      slot_q;
  logic                   delay_q;
  logic                   failed_q;

  logic [PTR_W-1:0] cur_q;
  logic [PTR_W-1:0] head_q;
  logic [PTR_W-1:0] tail_q;
  logic [SLOTS-1:0] valid_q, locked_q, delayed_q, old_q, error_q;
  logic [SLOTS-1:0] nwr_q, pwr_q;   // link entry written since reset
  logic [AW-1:0]    rd_ix_q;
  logic             nwr_rq, pwr_rq;

  logic                   out_valid_q;
  logic [2:0]             out_st_q;
  logic [SLOT_W-1:0]      out_slot_q;
  logic [DEVICE_BITS-1:0] out_dev_q;
  logic [BLOCK_BITS-1:0]  out_blk_q;
  logic                   out_last_q;

  logic [AW-1:0]    cix, six;
  logic [PTR_W-1:0] slot_p, ix_ext;
  logic             slot_in;

  logic             nx_we, pv_we, tg_we, rd_en;
  logic [AW-1:0]    nx_wa, pv_wa;
  logic [PTR_W-1:0] nx_wd, pv_wd;
  logic [PTR_W-1:0] nx_ram, pv_ram, rd_next, rd_prev, next_rst, prev_rst;
  logic [TW-1:0]    tg_ram;
  logic [DEVICE_BITS-1:0] tag_dev;
  logic [BLOCK_BITS-1:0]  tag_blk;
  logic             out_free;

  assign cix     = cur_q[AW-1:0];
  assign slot_p  = PTR_W'(slot_q);
  assign slot_in = slot_p < PTR_W'(SLOTS);
  assign six     = slot_p[AW-1:0];

  // links never written since reset read as the initial in-order chain
  assign ix_ext   = PTR_W'(rd_ix_q);
  assign next_rst = (ix_ext == PTR_W'(SLOTS - 1)) ? NIL_SLOT : ix_ext + 1'b1;
  assign prev_rst = (ix_ext == '0) ? NIL_SLOT : ix_ext - 1'b1;
  assign rd_next  = nwr_rq ? nx_ram : next_rst;
  assign rd_prev  = pwr_rq ? pv_ram : prev_rst;
  assign tag_dev  = tg_ram[TW-1:BLOCK_BITS];
  assign tag_blk  = tg_ram[BLOCK_BITS-1:0];

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    rd_en = (cmd_i.op == OP_RD_CUR);
    tg_we = (cmd_i.op == OP_RETAG);
    nx_we = 1'b0;
    nx_wa = cix;
    nx_wd = NIL_SLOT;
    pv_we = 1'b0;
    pv_wa = cix;
    pv_wd = NIL_SLOT;
    case (cmd_i.op)
      OP_UNLINK_LOCK: begin
        nx_we = (rd_prev != NIL_SLOT);
        nx_wa = rd_prev[AW-1:0];
        nx_wd = rd_next;
        pv_we = (rd_next != NIL_SLOT);
        pv_wa = rd_next[AW-1:0];
        pv_wd = rd_prev;
      end
      OP_PUSH_HEAD_A: begin
        nx_we = 1'b1;
        nx_wd = head_q;
        pv_we = 1'b1;
      end
      OP_PUSH_HEAD_B: begin
        pv_we = (head_q != NIL_SLOT);
        pv_wa = head_q[AW-1:0];
        pv_wd = cur_q;
      end
      OP_PUSH_TAIL_A: begin
        pv_we = 1'b1;
        pv_wd = tail_q;
        nx_we = 1'b1;
      end
      OP_PUSH_TAIL_B: begin
        nx_we = (tail_q != NIL_SLOT);
        nx_wa = tail_q[AW-1:0];
        nx_wd = cur_q;
      end
      default: ;
    endcase
  end

  bbcm_ram #(.WIDTH(PTR_W), .DEPTH(SLOTS)) u_next_ram (
    .clk_i(clk_i), .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd),
    .re_i(rd_en), .raddr_i(cix), .rdata_o(nx_ram)
  );

  bbcm_ram #(.WIDTH(PTR_W), .DEPTH(SLOTS)) u_prev_ram (
    .clk_i(clk_i), .we_i(pv_we), .waddr_i(pv_wa), .wdata_i(pv_wd),
    .re_i(rd_en), .raddr_i(cix), .rdata_o(pv_ram)
  );

  bbcm_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_tag_ram (
    .clk_i(clk_i), .we_i(tg_we), .waddr_i(cix), .wdata_i({dev_q, blk_q}),
    .re_i(rd_en), .raddr_i(cix), .rdata_o(tg_ram)
  );

  // request, cursor and read-side registers
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_ix_q <= cix;
      nwr_rq  <= nwr_q[cix];
      pwr_rq  <= pwr_q[cix];
    end
    case (cmd_i.op)
      OP_LOAD: begin
        mode_q   <= mode_i;
        dev_q    <= req_device_i;
        blk_q    <= req_block_i;
        slot_q   <= req_slot_i;
        delay_q  <= mark_delayed_i;
        failed_q <= io_failed_i;
        cur_q    <= '0;
      end
      OP_INC:        cur_q <= cur_q + 1'b1;
      OP_CUR_HEAD:   cur_q <= head_q;
      OP_CUR_NEXT:   cur_q <= rd_next;
      OP_INVAL_NEXT: cur_q <= rd_next;
      OP_SET_FLAGS:  cur_q <= slot_p;
      default: ;
    endcase
  end

  // slot flags, list ends and link written bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      locked_q  <= '0;
      delayed_q <= '0;
      old_q     <= '0;
      error_q   <= '0;
      nwr_q     <= '0;
      pwr_q     <= '0;
      head_q    <= '0;
      tail_q    <= PTR_W'(SLOTS - 1);
    end else begin
      if (nx_we) nwr_q[nx_wa] <= 1'b1;
      if (pv_we) pwr_q[pv_wa] <= 1'b1;
      case (cmd_i.op)
        OP_UNLINK_LOCK: begin
          locked_q[cix] <= 1'b1;
          if (rd_prev == NIL_SLOT) head_q <= rd_next;
          if (rd_next == NIL_SLOT) tail_q <= rd_prev;
        end
        OP_MARK_OLD: old_q[cix] <= 1'b1;
        OP_RETAG: begin
          valid_q[cix]   <= 1'b0;
          delayed_q[cix] <= 1'b0;
          old_q[cix]     <= 1'b0;
          error_q[cix]   <= 1'b0;
        end
        OP_SET_FLAGS: begin
          if (mode_q == MODE_RELEASE) begin
            if (delay_q) delayed_q[six] <= 1'b1;
          end else begin
            error_q[six]   <= failed_q;
            valid_q[six]   <= !failed_q;
            delayed_q[six] <= 1'b0;
          end
        end
        OP_PUSH_HEAD_B: begin
          if (head_q == NIL_SLOT) tail_q <= cur_q;
          head_q        <= cur_q;
          old_q[cix]    <= 1'b0;
          locked_q[cix] <= 1'b0;
        end
        OP_PUSH_TAIL_B: begin
          if (tail_q == NIL_SLOT) head_q <= cur_q;
          tail_q        <= cur_q;
          locked_q[cix] <= 1'b0;
        end
        OP_MARK_VALID: if (slot_in) valid_q[six] <= 1'b1;
        OP_INVAL_NEXT: if (tag_dev == dev_q) valid_q[cix] <= 1'b0;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_st_q   <= cmd_i.st;
      out_last_q <= (cmd_i.st != RS_WB);
      out_dev_q  <= (cmd_i.st == RS_WB) ? tag_dev : '0;
      out_blk_q  <= (cmd_i.st == RS_WB) ? tag_blk : '0;
      case (cmd_i.sel)
        SEL_REQ: out_slot_q <= slot_q;
        SEL_CUR: out_slot_q <= cur_q[SLOT_W-1:0];
        default: out_slot_q <= '0;
      endcase
    end
  end

  assign stat_o.mode        = mode_q;
  assign stat_o.slot_ok     = slot_in && locked_q[six];
  assign stat_o.match       = valid_q[cix] && (tag_dev == dev_q) && (tag_blk == blk_q);
  assign stat_o.locked_cur  = locked_q[cix];
  assign stat_o.delayed_cur = delayed_q[cix];
  assign stat_o.cur_nil     = (cur_q == NIL_SLOT);
  assign stat_o.cur_last    = (cur_q == PTR_W'(SLOTS - 1));
  assign stat_o.to_head     = old_q[cix] || !valid_q[cix];
  assign stat_o.failed      = failed_q;
  assign stat_o.out_free    = out_free;

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_st_q;
  assign res_slot_o   = out_slot_q;
  assign res_device_o = out_dev_q;
  assign res_block_o  = out_blk_q;
  assign last_o       = out_last_q;

endmodule

// File: sv/bbcm_ctrl.sv
// Controller: sequences tag scan, free-list walks and list updates.
module bbcm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bbcm_pkg::dp_stat_t stat_i,
  output bbcm_pkg::dp_cmd_t  cmd_o
);
  import bbcm_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o.op   = OP_NONE;
    cmd_o.emit = 1'b0;
    cmd_o.st   = RS_DONE;
    cmd_o.sel  = SEL_ZERO;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.mode)
          MODE_FETCH: state_d = S_SCAN_RD;
          MODE_RELEASE, MODE_IO_DONE: begin
            if (stat_i.slot_ok) begin
              cmd_o.op = OP_SET_FLAGS;
              state_d  = S_PUSH_A;
            end else if (stat_i.out_free) begin
              cmd_o.emit = 1'b1;
              cmd_o.sel  = SEL_REQ;
              state_d    = S_IDLE;
            end
          end
          MODE_INVAL_DEV, MODE_FLUSH: begin
            cmd_o.op = OP_CUR_HEAD;
            state_d  = S_WALK_CHECK;
          end
          MODE_MARK_VALID: begin
            if (stat_i.out_free) begin
              cmd_o.op   = OP_MARK_VALID;
              cmd_o.emit = 1'b1;
              cmd_o.sel  = SEL_REQ;
              state_d    = S_IDLE;
            end
          end
          default: begin
            if (stat_i.out_free) begin
              cmd_o.emit = 1'b1;
              state_d    = S_IDLE;
            end
          end
        endcase
      end
      S_SCAN_RD: begin
        cmd_o.op = OP_RD_CUR;
        state_d  = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (stat_i.match) begin
          if (stat_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.sel  = SEL_CUR;
            state_d    = S_IDLE;
            if (stat_i.locked_cur) begin
              cmd_o.st = RS_WAIT_LOCKED;
            end else begin
              cmd_o.st = RS_HIT;
              cmd_o.op = OP_UNLINK_LOCK;
            end
          end
        end else if (stat_i.cur_last) begin
          cmd_o.op = OP_CUR_HEAD;
          state_d  = S_MISS_CHECK;
        end else begin
          cmd_o.op = OP_INC;
          state_d  = S_SCAN_RD;
        end
      end
      S_MISS_CHECK: begin
        if (!stat_i.cur_nil) begin
          cmd_o.op = OP_RD_CUR;
          state_d  = S_MISS_UNLINK;
        end else if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.st   = RS_WAIT_FREE;
          state_d    = S_IDLE;
        end
      end
      S_MISS_UNLINK: begin
        cmd_o.op = OP_UNLINK_LOCK;
        state_d  = S_MISS_EVAL;
      end
      S_MISS_EVAL: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_CUR;
          if (stat_i.delayed_cur) begin
            cmd_o.op = OP_MARK_OLD;
            cmd_o.st = RS_WB;
            state_d  = S_MISS_HEAD;
          end else begin
            cmd_o.op = OP_RETAG;
            cmd_o.st = RS_ALLOC;
            state_d  = S_IDLE;
          end
        end
      end
      S_MISS_HEAD: begin
        cmd_o.op = OP_CUR_HEAD;
        state_d  = S_MISS_CHECK;
      end
      S_PUSH_A: begin
        cmd_o.op = stat_i.to_head ? OP_PUSH_HEAD_A : OP_PUSH_TAIL_A;
        state_d  = S_PUSH_B;
      end
      S_PUSH_B: begin
        if (stat_i.out_free) begin
          cmd_o.op   = stat_i.to_head ? OP_PUSH_HEAD_B : OP_PUSH_TAIL_B;
          cmd_o.emit = 1'b1;
          cmd_o.sel  = SEL_REQ;
          cmd_o.st   = (stat_i.mode == MODE_IO_DONE && stat_i.failed) ? RS_IO_ERR : RS_DONE;
          state_d    = S_IDLE;
        end
      end
      S_WALK_CHECK: begin
        if (!stat_i.cur_nil) begin
          cmd_o.op = OP_RD_CUR;
          state_d  = S_WALK_EVAL;
        end else if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_WALK_EVAL: begin
        if (stat_i.mode == MODE_INVAL_DEV) begin
          cmd_o.op = OP_INVAL_NEXT;
          state_d  = S_WALK_CHECK;
        end else if (stat_i.delayed_cur) begin
          cmd_o.op = OP_UNLINK_LOCK;
          state_d  = S_FL_WB;
        end else begin
          cmd_o.op = OP_CUR_NEXT;
          state_d  = S_WALK_CHECK;
        end
      end
      S_FL_WB: begin
        if (stat_i.out_free) begin
          cmd_o.op   = OP_MARK_OLD;
          cmd_o.emit = 1'b1;
          cmd_o.st   = RS_WB;
          cmd_o.sel  = SEL_CUR;
          state_d    = S_FL_NEXT;
        end
      end
      S_FL_NEXT: begin
        // link data of the flushed slot is still held in the read registers
        cmd_o.op = OP_CUR_NEXT;
        state_d  = S_WALK_CHECK;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: sv/bbcm_checker.sv
// Port-level checks for the block buffer cache manager, bound to the top level.
module bbcm_checker #(
  parameter int unsigned DEVICE_BITS = 8,
  parameter int unsigned BLOCK_BITS  = 24
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [2:0]                  status_o,
  input logic [DEVICE_BITS-1:0]      res_device_o,
  input logic [BLOCK_BITS-1:0]       res_block_o,
  input logic                        last_o
);
  import bbcm_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken before the first finished");

  // only write-backs carry a tag, and only they are non-final
  a_tag_only_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != RS_WB) |-> (res_device_o == '0) && (res_block_o == '0))
    else $error("tag on a result that is not a write-back");

  a_last_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (status_o != RS_WB)))
    else $error("last flag does not match status");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != 3'd7))
    else $error("undefined status code");

endmodule

bind block_buffer_cache_manager_core bbcm_checker #(
  .DEVICE_BITS (DEVICE_BITS),
  .BLOCK_BITS  (BLOCK_BITS)
) u_bbcm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .res_device_o (res_device_o),
  .res_block_o  (res_block_o),
  .last_o       (last_o)
);

// File: tb/sv/tb.sv
// Testbench for the block buffer cache manager: directed and random items, scoreboard check.
`timescale 1ns / 1ps

module tb;
  import bbcm_pkg::*;

  localparam int NSLOT = 32;
  localparam int NIL   = 63;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    res_st_e     st;
    logic [4:0]  slot;
    logic [7:0]  dev;
    logic [23:0] blk;
    logic        last;
  } cache_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall_o;
  logic [2:0]  mode_q = '0;
  logic [7:0]  dev_q = '0;
  logic [23:0] blk_q = '0;
  logic [4:0]  slot_q = '0;
  logic        delay_q = 1'b0;
  logic        fail_q = 1'b0;
  logic        out_valid_o;
  logic        out_stall = 1'b1;
  logic [2:0]  status_o;
  logic [4:0]  res_slot_o;
  logic [7:0]  res_device_o;
  logic [23:0] res_block_o;
  logic        last_o;

  block_buffer_cache_manager_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall_o),
    .mode_i(mode_q), .req_device_i(dev_q), .req_block_i(blk_q), .req_slot_i(slot_q),
    .mark_delayed_i(delay_q), .io_failed_i(fail_q),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall),
    .status_o(status_o), .res_slot_o(res_slot_o), .res_device_o(res_device_o),
    .res_block_o(res_block_o), .last_o(last_o)
  );

  always #2 clk_i = ~clk_i;

  // shadow of the cache state
  logic [7:0]  sh_dev [NSLOT];
  logic [23:0] sh_blk [NSLOT];
  bit sh_valid [NSLOT], sh_locked [NSLOT], sh_delayed [NSLOT], sh_old [NSLOT];
  bit sh_err [NSLOT], sh_tagged [NSLOT];
  int sh_next [NSLOT], sh_prev [NSLOT];
  int sh_head, sh_tail;

  cache_res_t expected_q[$];
  int fails = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_req = 0, hold_left = 0;
  int cycles = 0;

  task automatic report(input string what, input cache_res_t got, input cache_res_t exp);
    $display("mismatch %s: got st=%0d slot=%0d dev=%0h blk=%0h last=%0d, exp st=%0d slot=%0d dev=%0h blk=%0h last=%0d",
             what, got.st, got.slot, got.dev, got.blk, got.last,
             exp.st, exp.slot, exp.dev, exp.blk, exp.last);
    fails++;
  endtask

  function automatic void add_res(res_st_e st, int slot, logic [7:0] dev, logic [23:0] blk,
                                  bit last);
    cache_res_t r;
    r.st = st; r.slot = slot[4:0]; r.dev = dev; r.blk = blk; r.last = last;
    expected_q.push_back(r);
  endfunction

  function automatic void list_unlink(int s);
    int p, n;
    p = sh_prev[s]; n = sh_next[s];
    if (p < NSLOT) sh_next[p] = n; else sh_head = n;
    if (n < NSLOT) sh_prev[n] = p; else sh_tail = p;
    sh_next[s] = NIL; sh_prev[s] = NIL;
  endfunction

  function automatic void return_slot(int s);
    if (sh_old[s] || !sh_valid[s]) begin
      sh_old[s] = 0;
      sh_prev[s] = NIL; sh_next[s] = sh_head;
      if (sh_head < NSLOT) sh_prev[sh_head] = s; else sh_tail = s;
      sh_head = s;
    end else begin
      sh_next[s] = NIL; sh_prev[s] = sh_tail;
      if (sh_tail < NSLOT) sh_next[sh_tail] = s; else sh_head = s;
      sh_tail = s;
    end
    sh_locked[s] = 0;
  endfunction

  function automatic void cache_reset();
    for (int i = 0; i < NSLOT; i++) begin
      sh_dev[i] = '0; sh_blk[i] = '0;
      sh_valid[i] = 0; sh_locked[i] = 0; sh_delayed[i] = 0; sh_old[i] = 0;
      sh_err[i] = 0; sh_tagged[i] = 0;
      sh_next[i] = (i + 1 < NSLOT) ? i + 1 : NIL;
      sh_prev[i] = (i > 0) ? i - 1 : NIL;
    end
    sh_head = 0; sh_tail = NSLOT - 1;
  endfunction

  // expected results of one accepted request
  function automatic void cache_predict(logic [2:0] mode, logic [7:0] dev, logic [23:0] blk,
                                        logic [4:0] slot, bit delay, bit failed);
    int i, s, n;
    case (mode)
      MODE_FETCH: begin
        for (i = 0; i < NSLOT; i++)
          if (sh_valid[i] && sh_dev[i] == dev && sh_blk[i] == blk) break;
        if (i < NSLOT) begin
          if (sh_locked[i]) add_res(RS_WAIT_LOCKED, i, '0, '0, 1);
          else begin
            sh_locked[i] = 1;
            list_unlink(i);
            add_res(RS_HIT, i, '0, '0, 1);
          end
          return;
        end
        for (i = 0; i < NSLOT && sh_head < NSLOT; i++) begin
          s = sh_head;
          list_unlink(s);
          sh_locked[s] = 1;
          if (sh_delayed[s]) begin
            sh_old[s] = 1;
            add_res(RS_WB, s, sh_dev[s], sh_blk[s], 0);
            continue;
          end
          sh_dev[s] = dev; sh_blk[s] = blk; sh_tagged[s] = 1;
          sh_valid[s] = 0; sh_delayed[s] = 0; sh_old[s] = 0; sh_err[s] = 0;
          add_res(RS_ALLOC, s, '0, '0, 1);
          return;
        end
        add_res(RS_WAIT_FREE, 0, '0, '0, 1);
      end
      MODE_RELEASE, MODE_IO_DONE: begin
        if (!sh_locked[slot]) begin
          add_res(RS_DONE, slot, '0, '0, 1);
        end else if (mode == MODE_RELEASE) begin
          if (delay) sh_delayed[slot] = 1;
          return_slot(slot);
          add_res(RS_DONE, slot, '0, '0, 1);
        end else begin
          sh_err[slot] = failed; sh_valid[slot] = !failed; sh_delayed[slot] = 0;
          return_slot(slot);
          add_res(failed ? RS_IO_ERR : RS_DONE, slot, '0, '0, 1);
        end
      end
      MODE_INVAL_DEV: begin
        s = sh_head;
        for (i = 0; i < NSLOT && s < NSLOT; i++) begin
          if (sh_dev[s] == dev) sh_valid[s] = 0;
          s = sh_next[s];
        end
        add_res(RS_DONE, 0, '0, '0, 1);
      end
      MODE_FLUSH: begin
        s = sh_head;
        for (i = 0; i < NSLOT && s < NSLOT; i++) begin
          n = sh_next[s];
          if (sh_delayed[s]) begin
            sh_old[s] = 1; sh_locked[s] = 1;
            list_unlink(s);
            add_res(RS_WB, s, sh_dev[s], sh_blk[s], 0);
          end
          s = n;
        end
        add_res(RS_DONE, 0, '0, '0, 1);
      end
      MODE_MARK_VALID: begin
        sh_valid[slot] = 1;
        add_res(RS_DONE, slot, '0, '0, 1);
      end
      default: add_res(RS_DONE, 0, '0, '0, 1);
    endcase
  endfunction

  // drive one item and hold it until accepted
  task automatic send_item(input mode_e mode, input logic [7:0] dev, input logic [23:0] blk,
                           input logic [4:0] slot, input bit delay, input bit failed);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    mode_q <= mode; dev_q <= dev; blk_q <= blk; slot_q <= slot;
    delay_q <= delay; fail_q <= failed;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    cache_predict(mode, dev, blk, slot, delay, failed);
  endtask

  function automatic int pick_slot(bit want_locked, bit want_tagged);
    int cand[$];
    for (int i = 0; i < NSLOT; i++)
      if ((!want_locked || sh_locked[i]) && (!want_tagged || sh_tagged[i])) cand.push_back(i);
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(cand.size() - 1)];
  endfunction

  function automatic int locked_count();
    int c = 0;
    for (int i = 0; i < NSLOT; i++) c += sh_locked[i];
    return c;
  endfunction

  // one well-formed random request drawn from the current cache state
  task automatic send_random();
    int r, s;
    logic [7:0]  dev;
    logic [23:0] blk;
    r = $urandom_range(99);
    dev = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    blk = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(40));
    if (locked_count() > 20 && r < 45) r = 50;
    if (r < 45) begin
      send_item(MODE_FETCH, dev, blk, 5'($urandom), 1'($urandom), 1'($urandom));
    end else if (r < 88) begin
      s = pick_slot($urandom_range(9) != 0, 0);
      if (s < 0) s = $urandom_range(NSLOT - 1);
      send_item(($urandom_range(1) != 0) ? MODE_RELEASE : MODE_IO_DONE, dev, blk, s[4:0],
                $urandom_range(2) == 0, $urandom_range(3) == 0);
    end else if (r < 93) begin
      s = pick_slot(0, 1);
      if (s < 0) send_item(MODE_FLUSH, dev, blk, '0, 0, 0);
      else send_item(MODE_MARK_VALID, dev, blk, s[4:0], 1'($urandom), 1'($urandom));
    end else if (r < 97) begin
      send_item(MODE_INVAL_DEV, dev, blk, 5'($urandom), 1'($urandom), 1'($urandom));
    end else begin
      send_item(MODE_FLUSH, dev, blk, 5'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_directed();
    send_item(MODE_FETCH, 8'hFF, 24'hFFFFFF, 5'd31, 1, 1);   // miss, slot 0
    send_item(MODE_IO_DONE, 8'h00, 24'h0, 5'd0, 0, 1);       // read failed
    send_item(MODE_FETCH, 8'hFF, 24'hFFFFFF, 5'd0, 0, 0);    // error slot back at head
    send_item(MODE_IO_DONE, 8'h00, 24'h0, 5'd0, 0, 0);       // read ok, now valid
    send_item(MODE_FETCH, 8'hFF, 24'hFFFFFF, 5'd0, 0, 0);    // hit
    send_item(MODE_FETCH, 8'hFF, 24'hFFFFFF, 5'd0, 0, 0);    // locked hit
    send_item(MODE_RELEASE, 8'h00, 24'h0, 5'd0, 1, 0);       // delayed write
    send_item(MODE_RELEASE, 8'h00, 24'h0, 5'd31, 0, 0);      // not locked, ignored
    send_item(MODE_IO_DONE, 8'h00, 24'h0, 5'd17, 0, 1);      // not locked, ignored
    send_item(MODE_FETCH, 8'h00, 24'h000000, 5'd0, 0, 0);    // alloc slot 1
    send_item(MODE_MARK_VALID, 8'h00, 24'h0, 5'd1, 0, 0);
    send_item(MODE_RELEASE, 8'h00, 24'h0, 5'd1, 1, 0);
    send_item(MODE_FLUSH, 8'h00, 24'h0, 5'd0, 0, 0);         // two write-backs
    send_item(MODE_IO_DONE, 8'h00, 24'h0, 5'd0, 0, 0);
    send_item(MODE_IO_DONE, 8'h00, 24'h0, 5'd1, 0, 1);
    send_item(MODE_INVAL_DEV, 8'hFF, 24'h0, 5'd0, 0, 0);
    send_item(MODE_FETCH, 8'hFF, 24'hFFFFFF, 5'd0, 0, 0);    // miss after invalidate
    send_item(MODE_RELEASE, 8'h00, 24'h0, 5'd0, 0, 0);
    send_item(MODE_INVAL_DEV, 8'h00, 24'h0, 5'd0, 0, 0);
    send_item(MODE_FLUSH, 8'h00, 24'h0, 5'd0, 0, 0);         // nothing to flush
  endtask

  task automatic test_random(input int n, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) send_random();
  endtask

  // receiver holds off while items keep coming, so the block backs up
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 400;
    repeat (30) send_random();
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // stall driver, with an optional long hold-off counted here
  always @(posedge clk_i) begin
    if (!rst_ni) out_stall <= 1'b1;
    else if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct;
    end
  end

  always @(negedge clk_i) begin
    cache_res_t got, exp;
    if (rst_ni && out_valid_o && !out_stall) begin
      got.st = res_st_e'(status_o); got.slot = res_slot_o; got.dev = res_device_o;
      got.blk = res_block_o; got.last = last_o;
      if (expected_q.size() == 0) begin
        report("unexpected item", got, got);
      end else begin
        exp = expected_q.pop_front();
        if (got.st != exp.st) report("status", got, exp);
        if (got.slot != exp.slot) report("slot", got, exp);
        if (got.dev != exp.dev) report("device", got, exp);
        if (got.blk != exp.blk) report("block", got, exp);
        if (got.last != exp.last) report("last", got, exp);
      end
    end
  end

  initial begin
    cache_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(110, 25, 66);
    test_random(110, 66, 25);
    test_backpressure();
    test_random(110, 0, 0);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fails == 0 && expected_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
